/* rtl/crc14_fav_pkg.sv */
// Shared types, constants and CRC step functions for the CRC-14 frame block.
package crc14_fav_pkg;

  localparam int unsigned CrcWidth   = 14;
  localparam int unsigned PayloadLen = 10;
  localparam int unsigned FrameLen   = 12;

  localparam logic [CrcWidth-1:0] PolyReset = 14'h2757;
  localparam logic [7:0]          TopMask   = 8'hF8;

  localparam logic [1:0] MODE_STREAM = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_VERIFY = 2'd2;

  // Byte positions inside a frame.
  localparam logic [3:0] POS_LAST_PAYLOAD = 4'(PayloadLen - 1);
  localparam logic [3:0] POS_CRC_MID      = 4'(FrameLen - 2);
  localparam logic [3:0] POS_CRC_END      = 4'(FrameLen - 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [CrcWidth-1:0] crc_value;
    logic                crc_ok;
    logic                last_out;
  } out_rsp_t;

  function automatic logic [CrcWidth-1:0] crc_step(
    input logic [CrcWidth-1:0] crc,
    input logic                din,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] nxt;
    nxt = {crc[CrcWidth-2:0], 1'b0};
    if (crc[CrcWidth-1] ^ din) begin
      nxt = nxt ^ poly;
    end
    return nxt;
  endfunction

  // Feeds the leading cnt bits of a byte, MSB first; counts above eight act as eight.
  function automatic logic [CrcWidth-1:0] crc_byte(
    input logic [CrcWidth-1:0] crc,
    input logic [7:0]          data,
    input logic [3:0]          cnt,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        c = crc_step(c, data[3'(7 - i)], poly);
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc14_fav_in_if.sv */
// Request channel carrying one input byte and its control fields.
interface crc14_fav_in_if import crc14_fav_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crc14_fav_out_if.sv */
// Result channel carrying one output byte, CRC and verdict.
interface crc14_fav_out_if import crc14_fav_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crc14_frame_append_verify.sv */
// CRC-14 stream, frame append and frame verify block, top level.
//
//   channel  dir  request                       meaning
//   in_i     in   mode, data_byte, bit_count,   one byte per request
//                 last
//   out_o    out  out_byte, crc_value, crc_ok,  one or three results per request,
//                 last_out                      none for mode 3, early verify bytes
//   cfg      in   cfg_we_i, cfg_wdata_i         polynomial register
//
// For each accepted request, the byte update runs through an unrolled
// bit-serial CRC network straight into the state and a two-entry result queue.
// A final payload byte in append mode yields three results from one queue entry,
// which leaves the queue only after its third result is taken.
// Reset clears the state, the queue and sets the polynomial to 0x2757.
// A stalled output blocks input only once both queue entries are occupied.
module crc14_frame_append_verify import crc14_fav_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CrcWidth-1:0] cfg_wdata_i,
  crc14_fav_in_if.sink        in_i,
  crc14_fav_out_if.source     out_o
);

  typedef struct packed {
    out_rsp_t rsp;
    logic     triple;
  } entry_t;

  logic [CrcWidth-1:0] poly_q;
  logic [CrcWidth-1:0] crc_q, crc_d;
  logic [3:0]          pos_q, pos_d;
  logic                seen_q, seen_d;
  logic [CrcWidth-1:0] rcv_q, rcv_d;

  entry_t     fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] sub_q;

  logic   in_acc, out_acc, pop, push;
  entry_t push_entry;
  entry_t head;

  in_req_t             req;
  logic [CrcWidth-1:0] crc_base, crc_full, crc_tail;
  logic                seen_base, seen_new;
  logic [CrcWidth-1:0] rcv_base, rcv_final;
  logic [7:0]          masked;

  assign req      = in_i.data;
  assign in_i.ready = (cnt_q < 2'd2);
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // A frame item at position zero starts from a cleared frame state.
  always_comb begin
    crc_base  = (pos_q == 4'd0) ? '0 : crc_q;
    seen_base = (pos_q == 4'd0) ? 1'b0 : seen_q;
    rcv_base  = (pos_q == 4'd0) ? '0 : rcv_q;
    masked    = req.data_byte & TopMask;
    crc_full  = crc_byte(crc_base, req.data_byte, 4'd8, poly_q);
    // Final payload byte: top five bits, then five zero bits in total.
    crc_tail  = crc_byte(crc_base, masked, 4'd8, poly_q);
    crc_tail  = crc_step(crc_tail, 1'b0, poly_q);
    crc_tail  = crc_step(crc_tail, 1'b0, poly_q);
    seen_new  = seen_base || (req.data_byte != 8'd0);
    rcv_final = rcv_base | {11'd0, req.data_byte[7:5]};
  end

  always_comb begin
    crc_d      = crc_q;
    pos_d      = pos_q;
    seen_d     = seen_q;
    rcv_d      = rcv_q;
    push       = 1'b0;
    push_entry = '0;
    unique case (req.mode)
      MODE_STREAM: begin
        // Any open frame is abandoned, so the stream restarts from zero.
        push_entry.rsp.crc_value = crc_byte((pos_q == 4'd0) ? crc_q : '0,
                                            req.data_byte, req.bit_count, poly_q);
        push_entry.rsp.last_out  = req.last;
        push   = 1'b1;
        crc_d  = req.last ? '0 : push_entry.rsp.crc_value;
        pos_d  = '0;
        seen_d = 1'b0;
        rcv_d  = '0;
      end
      MODE_APPEND: begin
        push = 1'b1;
        if (pos_q < POS_LAST_PAYLOAD) begin
          crc_d  = crc_full;
          pos_d  = pos_q + 4'd1;
          seen_d = seen_base;
          rcv_d  = rcv_base;
          push_entry.rsp.out_byte  = req.data_byte;
          push_entry.rsp.crc_value = crc_full;
        end else begin
          crc_d  = '0;
          pos_d  = '0;
          seen_d = 1'b0;
          rcv_d  = '0;
          push_entry.rsp.out_byte  = masked | {5'd0, crc_tail[CrcWidth-1 -: 3]};
          push_entry.rsp.crc_value = crc_tail;
          push_entry.triple        = 1'b1;
        end
      end
      MODE_VERIFY: begin
        seen_d = seen_new;
        crc_d  = crc_base;
        rcv_d  = rcv_base;
        pos_d  = pos_q + 4'd1;
        if (pos_q < POS_LAST_PAYLOAD) begin
          crc_d = crc_full;
        end else if (pos_q == POS_LAST_PAYLOAD) begin
          crc_d = crc_tail;
          rcv_d = {req.data_byte[2:0], 11'd0};
        end else if (pos_q == POS_CRC_MID) begin
          rcv_d = rcv_base | {3'd0, req.data_byte, 3'd0};
        end else begin
          push = 1'b1;
          push_entry.rsp.crc_value = crc_base;
          push_entry.rsp.crc_ok    = seen_new && (crc_base == rcv_final);
          push_entry.rsp.last_out  = 1'b1;
          crc_d  = '0;
          pos_d  = '0;
          seen_d = 1'b0;
          rcv_d  = '0;
        end
      end
      default: begin
        // The unused mode code is dropped without effect.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      pos_q  <= '0;
      seen_q <= 1'b0;
      rcv_q  <= '0;
    end else if (in_acc) begin
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
      rcv_q  <= rcv_d;
    end
  end

  // Result queue: one entry per pushed request, expanded into one or three results.
  assign head    = fifo_q[rd_ptr_q];
  assign out_acc = out_o.valid && out_o.ready;
  assign pop     = out_acc && (!head.triple || (sub_q == 2'd2));

  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      fifo_q[wr_ptr_q] <= push_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      if (in_acc && push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        sub_q    <= '0;
      end else if (out_acc) begin
        sub_q <= sub_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, (in_acc && push)} - {1'b0, pop};
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);

  always_comb begin
    out_o.data = head.rsp;
    case (sub_q)
      2'd0: begin
        out_o.data.last_out = head.rsp.last_out && !head.triple;
      end
      2'd1: begin
        out_o.data.out_byte = head.rsp.crc_value[10:3];
        out_o.data.last_out = 1'b0;
      end
      default: begin
        out_o.data.out_byte = {head.rsp.crc_value[2:0], 5'd0};
        out_o.data.last_out = 1'b1;
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue count out of range");

  a_sub_triple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q != 2'd0) |-> (out_o.valid && head.triple))
    else $error("result index advanced on a single-result entry");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CRC_END)
    else $error("frame position beyond frame end");

  a_last_resets_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.data.last_out) |=> (sub_q == 2'd0))
    else $error("result index not rewound after last result");

endmodule

/* sim/crc14_frame_append_verify_tb.sv */
// Self-checking testbench for the CRC-14 stream, frame append and frame verify block.
module crc14_frame_append_verify_tb;
  import crc14_fav_pkg::*;

  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam int         StallLimit  = 2000;
  localparam int         DrainCycles = 6;
  localparam int         MaxPrinted  = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CrcWidth-1:0] cfg_wdata;

  crc14_fav_in_if  req_if ();
  crc14_fav_out_if rsp_if ();

  crc14_frame_append_verify dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block state, updated on every accepted request.
  logic [CrcWidth-1:0] poly_model;
  logic [CrcWidth-1:0] run_crc;
  logic [3:0]          frame_pos;
  logic                frame_nonzero;
  logic [CrcWidth-1:0] frame_rx_crc;
  out_rsp_t            crc_results_due[$];

  logic [7:0] frame_buf [FrameLen];
  bit         idle_on;
  int         error_count;
  int         requests_sent;
  int         results_checked;
  int         streams_closed;
  int         frames_appended;
  int         verdicts_good;
  int         verdicts_bad;
  int         stall_left;
  int         quiet_cycles;

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic logic [CrcWidth-1:0] crc_feed(input logic [CrcWidth-1:0] crc,
                                                   input logic [7:0] data, input int nbits);
    logic [CrcWidth-1:0] c;
    logic                fb;
    c = crc;
    for (int i = 0; i < nbits; i++) begin
      fb = c[CrcWidth-1] ^ data[7-i];
      c = {c[CrcWidth-2:0], 1'b0};
      if (fb) begin
        c = c ^ poly_model;
      end
    end
    return c;
  endfunction

  // The last payload byte keeps its top five bits and is followed by two zero bits.
  function automatic logic [CrcWidth-1:0] crc_tail(input logic [CrcWidth-1:0] crc,
                                                   input logic [7:0] data);
    return crc_feed(crc_feed(crc, data & TopMask, 8), 8'h00, 2);
  endfunction

  function automatic void clear_frame();
    run_crc       = '0;
    frame_pos     = '0;
    frame_nonzero = 1'b0;
    frame_rx_crc  = '0;
  endfunction

  function automatic void push_result(input logic [7:0] ob, input logic [CrcWidth-1:0] cv,
                                      input logic ok, input logic lo);
    crc_results_due.push_back({ob, cv, ok, lo});
  endfunction

  function automatic void predict_crc_results(input in_req_t r);
    int            nbits;
    logic [CrcWidth-1:0] c;
    logic          ok;
    if (r.mode == ModeUnused) begin
      return;
    end
    if (r.mode == MODE_STREAM) begin
      if (frame_pos != 0) begin
        clear_frame();
      end
      nbits = (r.bit_count > 8) ? 8 : int'(r.bit_count);
      run_crc = crc_feed(run_crc, r.data_byte, nbits);
      push_result(8'h00, run_crc, 1'b0, r.last);
      if (r.last) begin
        run_crc = '0;
        streams_closed++;
      end
      return;
    end
    if (frame_pos == 0) begin
      clear_frame();
    end
    if (r.mode == MODE_APPEND) begin
      if (frame_pos < POS_LAST_PAYLOAD) begin
        run_crc = crc_feed(run_crc, r.data_byte, 8);
        frame_pos++;
        push_result(r.data_byte, run_crc, 1'b0, 1'b0);
      end else begin
        c = crc_tail(run_crc, r.data_byte);
        push_result((r.data_byte & TopMask) | 8'(c[13:11]), c, 1'b0, 1'b0);
        push_result(c[10:3], c, 1'b0, 1'b0);
        push_result({c[2:0], 5'b0}, c, 1'b0, 1'b1);
        frames_appended++;
        clear_frame();
      end
      return;
    end
    if (r.data_byte != 0) begin
      frame_nonzero = 1'b1;
    end
    if (frame_pos < POS_LAST_PAYLOAD) begin
      run_crc = crc_feed(run_crc, r.data_byte, 8);
    end else if (frame_pos == POS_LAST_PAYLOAD) begin
      run_crc = crc_tail(run_crc, r.data_byte);
      frame_rx_crc = {r.data_byte[2:0], 11'b0};
    end else if (frame_pos == POS_CRC_MID) begin
      frame_rx_crc = frame_rx_crc | {3'b0, r.data_byte, 3'b0};
    end else begin
      frame_rx_crc = frame_rx_crc | {11'b0, r.data_byte[7:5]};
      ok = frame_nonzero && (run_crc == frame_rx_crc);
      push_result(8'h00, run_crc, ok, 1'b1);
      if (ok) begin
        verdicts_good++;
      end else begin
        verdicts_bad++;
      end
      clear_frame();
      return;
    end
    frame_pos++;
  endfunction

  // Requests are predicted before results are checked, all on the same sampling edge.
  always @(posedge clk) begin : result_monitor
    out_rsp_t got;
    out_rsp_t want;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        predict_crc_results(req_if.data);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (crc_results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %p", got));
        end else begin
          want = crc_results_due.pop_front();
          results_checked++;
          if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
          end
          if (got.crc_value !== want.crc_value) begin
            report_mismatch($sformatf("crc_value %h, want %h", got.crc_value, want.crc_value));
          end
          if (got.crc_ok !== want.crc_ok) begin
            report_mismatch($sformatf("crc_ok %b, want %b", got.crc_ok, want.crc_ok));
          end
          if (got.last_out !== want.last_out) begin
            report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no request or result moved for %0d cycles", StallLimit);
        $display("crc14_frame_append_verify_tb: done, errors");
        $finish;
      end
    end
  end

  // Result side back-pressure in bursts of random length, started only while idle_on is set.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [7:0] data,
                              input logic [3:0] cnt, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= {mode, data, cnt, last};
    do @(posedge clk); while (!req_if.ready);
    if (mode != ModeUnused) begin
      requests_sent++;
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  // Holds the sender until every outstanding result has been checked.
  task automatic wait_drained();
    go_quiet();
    while (crc_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_crc_poly(input logic [CrcWidth-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    poly_model = value;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends frame_buf[0..count-1] in one mode; bit_count and last are noise there.
  task automatic send_frame(input logic [1:0] mode, input int count);
    for (int i = 0; i < count; i++) begin
      send_request(mode, frame_buf[i], 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Fills frame_buf with a payload and the CRC field the current polynomial gives it.
  task automatic build_good_frame();
    logic [CrcWidth-1:0] c;
    c = '0;
    for (int i = 0; i < PayloadLen; i++) begin
      frame_buf[i] = rand_byte();
    end
    for (int i = 0; i < PayloadLen - 1; i++) begin
      c = crc_feed(c, frame_buf[i], 8);
    end
    c = crc_tail(c, frame_buf[PayloadLen-1]);
    frame_buf[PayloadLen-1] = (frame_buf[PayloadLen-1] & TopMask) | 8'(c[13:11]);
    frame_buf[PayloadLen]   = c[10:3];
    // The low five bits of the last byte carry no CRC bits and are left random.
    frame_buf[PayloadLen+1] = {c[2:0], 5'($urandom_range(0, 31))};
  endtask

  task automatic run_random_sequence();
    int pick;
    int len;
    int bit_idx;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      for (int i = 0; i < PayloadLen; i++) begin
        frame_buf[i] = rand_byte();
      end
      send_frame(MODE_APPEND, PayloadLen);
    end else if (pick < 56) begin
      build_good_frame();
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < FrameLen; i++) begin
            frame_buf[i] = 8'h00;
          end
        end
        1, 2: begin
          bit_idx = $urandom_range(0, FrameLen * 8 - 1);
          frame_buf[bit_idx / 8][bit_idx % 8] = ~frame_buf[bit_idx / 8][bit_idx % 8];
        end
        default: ;
      endcase
      send_frame(MODE_VERIFY, FrameLen);
    end else if (pick < 76) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_request(MODE_STREAM, rand_byte(), 4'($urandom_range(0, 15)), i == len - 1);
      end
    end else if (pick < 88) begin
      // Unfinished frame: the next request abandons it or continues it in another mode.
      for (int i = 0; i < FrameLen; i++) begin
        frame_buf[i] = rand_byte();
      end
      if ($urandom_range(0, 1) == 0) begin
        send_frame(MODE_APPEND, $urandom_range(1, PayloadLen - 1));
      end else begin
        send_frame(MODE_VERIFY, $urandom_range(1, FrameLen - 1));
      end
    end else if (pick < 96) begin
      len = $urandom_range(3, 8);
      for (int i = 0; i < len; i++) begin
        send_request(2'($urandom_range(0, 3)), rand_byte(), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
      end
    end else begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        send_request(ModeUnused, rand_byte(), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_edge_cases();
    idle_on = 1'b1;
    send_request(MODE_STREAM, 8'hFF, 4'd8, 1'b0);
    send_request(MODE_STREAM, 8'h00, 4'd0, 1'b0);
    send_request(MODE_STREAM, 8'hA5, 4'd15, 1'b0);
    send_request(MODE_STREAM, 8'h5A, 4'd3, 1'b1);
    // A stream made only of empty bytes must give zero.
    send_request(MODE_STREAM, 8'hFF, 4'd0, 1'b1);
    send_request(ModeUnused, 8'hFF, 4'd15, 1'b1);
    for (int i = 0; i < FrameLen; i++) begin
      frame_buf[i] = 8'hFF;
    end
    send_frame(MODE_APPEND, PayloadLen);
    // The all-zero frame has a matching CRC field but must be rejected.
    for (int i = 0; i < FrameLen; i++) begin
      frame_buf[i] = 8'h00;
    end
    send_frame(MODE_VERIFY, FrameLen);
    wait_drained();
  endtask

  task automatic test_random_traffic(input logic [CrcWidth-1:0] poly, input int count);
    int stop_at;
    write_crc_poly(poly);
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_random_sequence();
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  task automatic test_full_rate(input int count);
    int stop_at;
    idle_on = 1'b0;
    write_crc_poly(PolyReset);
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      run_random_sequence();
    end
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    idle_on      = 1'b0;
    poly_model   = PolyReset;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_cases();
    test_random_traffic(14'h3FFF, 50);
    test_random_traffic(14'h0000, 40);
    test_random_traffic(14'($urandom_range(0, 16383)), 50);
    test_random_traffic(14'($urandom_range(0, 16383)), 50);
    test_random_traffic(14'h2AAA, 40);
    test_full_rate(70);

    $display("covered %0d requests and %0d results under six polynomial settings",
             requests_sent, results_checked);
    $display("streams closed %0d, frames appended %0d, verify good %0d, verify bad %0d",
             streams_closed, frames_appended, verdicts_good, verdicts_bad);
    if (error_count == 0) begin
      $display("crc14_frame_append_verify_tb: done, clean");
    end else begin
      $display("crc14_frame_append_verify_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/crc14_fav_pkg.sv
rtl/crc14_fav_in_if.sv
rtl/crc14_fav_out_if.sv
rtl/crc14_frame_append_verify.sv
sim/crc14_frame_append_verify_tb.sv
